// ===== sv/hps_pkg.sv =====
// hps_pkg: shared types, constants and the pattern step table of the
// haptic pattern sequencer. No dependencies.
`timescale 1ns / 1ps

package hps_pkg;

	localparam int TIMESTAMP_BITS_DEF = 32;
	localparam int LINE_MAX_DEF = 8;
	localparam int NPAT = 5;
	localparam int BLINK_MS = 250;
	localparam int LAST_STEP = 17;   // highest step index reached by the longest pattern (its end entry)

	// register indexes
	localparam logic [2:0] CFG_LINK_TIMEOUT = 3'd0;
	localparam logic [2:0] CFG_COOL_BOLLARD = 3'd1;
	localparam logic [2:0] CFG_COOL_RED     = 3'd2;
	localparam logic [2:0] CFG_COOL_GREEN   = 3'd3;
	localparam logic [2:0] CFG_KICK_LEVEL   = 3'd4;
	localparam logic [2:0] CFG_HOLD_LEVEL   = 3'd5;
	localparam logic [2:0] CFG_HIGH_LEVEL   = 3'd6;

	// register reset values
	localparam logic [15:0] RST_LINK_TIMEOUT = 16'd2500;
	localparam logic [15:0] RST_COOL_BOLLARD = 16'd2500;
	localparam logic [15:0] RST_COOL_RED     = 16'd3000;
	localparam logic [15:0] RST_COOL_GREEN   = 16'd4000;
	localparam logic [7:0]  RST_KICK_LEVEL   = 8'd255;
	localparam logic [7:0]  RST_HOLD_LEVEL   = 8'd175;
	localparam logic [7:0]  RST_HIGH_LEVEL   = 8'd255;

	// pattern ids
	localparam logic [2:0] PAT_LEFT  = 3'd0;
	localparam logic [2:0] PAT_RIGHT = 3'd1;
	localparam logic [2:0] PAT_FRONT = 3'd2;
	localparam logic [2:0] PAT_RED   = 3'd3;
	localparam logic [2:0] PAT_GREEN = 3'd4;

	// LED bit patterns: bit0 red, bit1 green, bit2 blue
	localparam logic [2:0] LED_OFF   = 3'b000;
	localparam logic [2:0] LED_RED   = 3'b001;
	localparam logic [2:0] LED_GREEN = 3'b010;
	localparam logic [2:0] LED_BLUE  = 3'b100;

	// characters
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_VT  = 8'd11;
	localparam logic [7:0] CH_FF  = 8'd12;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_0   = 8'd48;
	localparam logic [7:0] CH_1   = 8'd49;
	localparam logic [7:0] CH_2   = 8'd50;
	localparam logic [7:0] CH_3   = 8'd51;
	localparam logic [7:0] CH_4   = 8'd52;
	localparam logic [7:0] CH_5   = 8'd53;

	// motor level codes
	localparam logic [1:0] LV_OFF  = 2'd0;
	localparam logic [1:0] LV_KICK = 2'd1;
	localparam logic [1:0] LV_HOLD = 2'd2;
	localparam logic [1:0] LV_HIGH = 2'd3;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} hps_in_t;

	typedef struct packed {
		logic [7:0] motor_left;
		logic [7:0] motor_right;
		logic       led_red;
		logic       led_green;
		logic       led_blue;
		logic       pattern_busy;
		logic [2:0] pattern_id;
		logic       link_lost;
	} hps_out_t;

	// end-of-line event from the line parser
	typedef struct packed {
		logic       refresh;   // line holding a non-whitespace character seen
		logic       led_we;
		logic [2:0] led;
		logic       req;
		logic [2:0] pat;
	} hps_line_evt_t;

	typedef struct packed {
		logic [1:0] l;
		logic [1:0] r;
		logic [9:0] ms;
	} hps_step_t;

	function automatic hps_step_t step_rom(input logic [2:0] pid, input logic [4:0] idx);
		hps_step_t s;
		logic [1:0] kl, kr, hl, hr;
		kl = (pid != PAT_RIGHT) ? LV_KICK : LV_OFF;
		kr = (pid != PAT_LEFT) ? LV_KICK : LV_OFF;
		hl = (pid != PAT_RIGHT) ? LV_HIGH : LV_OFF;
		hr = (pid != PAT_LEFT) ? LV_HIGH : LV_OFF;
		s = '{l: LV_OFF, r: LV_OFF, ms: 10'd0};
		unique case (pid)
			PAT_LEFT, PAT_RIGHT, PAT_FRONT: begin
				unique case (idx)
					5'd0, 5'd3: s = '{l: kl, r: kr, ms: 10'd60};
					5'd1, 5'd4: s = '{l: hl, r: hr, ms: 10'd90};
					5'd2:       s = '{l: LV_OFF, r: LV_OFF, ms: 10'd170};
					default:    s = '{l: LV_OFF, r: LV_OFF, ms: 10'd0};
				endcase
			end
			PAT_RED: begin
				unique case (idx)
					5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15:
						s = '{l: LV_KICK, r: LV_KICK, ms: 10'd45};
					5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16:
						s = '{l: LV_HOLD, r: LV_HOLD, ms: 10'd45};
					5'd2, 5'd5, 5'd11, 5'd14:
						s = '{l: LV_OFF, r: LV_OFF, ms: 10'd150};
					5'd8:    s = '{l: LV_OFF, r: LV_OFF, ms: 10'd450};
					default: s = '{l: LV_OFF, r: LV_OFF, ms: 10'd0};
				endcase
			end
			PAT_GREEN: begin
				unique case (idx)
					5'd0:    s = '{l: LV_KICK, r: LV_KICK, ms: 10'd80};
					5'd1:    s = '{l: LV_HIGH, r: LV_HIGH, ms: 10'd800};
					default: s = '{l: LV_OFF, r: LV_OFF, ms: 10'd0};
				endcase
			end
			default: s = '{l: LV_OFF, r: LV_OFF, ms: 10'd0};
		endcase
		return s;
	endfunction

	function automatic logic [1:0] prio_of(input logic [2:0] pid);
		logic [1:0] p;
		unique case (pid)
			PAT_RED:   p = 2'd3;
			PAT_GREEN: p = 2'd1;
			default:   p = 2'd2;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] level_of(input logic [1:0] code, input logic [7:0] kick,
			input logic [7:0] hold, input logic [7:0] high);
		logic [7:0] v;
		unique case (code)
			LV_KICK: v = kick;
			LV_HOLD: v = hold;
			LV_HIGH: v = high;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/haptic_pattern_sequencer.sv =====
// haptic_pattern_sequencer: top level; tick clock, watchdog, pattern requests
// and step player. Depends on hps_pkg and hps_line_parser.
`timescale 1ns / 1ps

// One item is accepted per clock cycle unless the output stalls, and each
// gives one result: the item is captured in an input register, from which
// a single pass of logic, once the output can advance, updates the clock,
// line, watchdog and player state and loads the result register. That
// state update, with the millisecond clock compares and the deadline add,
// sets the rate. Register writes are taken at any time (cfg_ready is always
// high) and must only be issued while the block is idle. The red blink phase
// is tracked by a counter beside the millisecond clock instead of a division.
module haptic_pattern_sequencer #(
	parameter int TIMESTAMP_BITS = hps_pkg::TIMESTAMP_BITS_DEF,
	parameter int LINE_MAX = hps_pkg::LINE_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hps_pkg::hps_in_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output hps_pkg::hps_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import hps_pkg::*;

	localparam int TS = TIMESTAMP_BITS;

	// config registers
	logic [15:0] link_timeout_q, cool_bollard_q, cool_red_q, cool_green_q;
	logic [7:0]  kick_q, hold_q, high_q;

	// handshake / pipeline
	logic     valid_s1, out_valid_q, advance, proc;
	hps_in_t  item_s1;
	hps_out_t out_q;

	// state
	logic [TS-1:0] now_q, last_cmd_q, dl_q;
	logic [TS-1:0] last_start_q [NPAT];
	logic [7:0]    blink_sub_q;
	logic          blink_par_q;
	logic          play_q;
	logic [2:0]    act_q;
	logic [4:0]    step_q;
	logic [7:0]    left_q, right_q;
	logic [2:0]    led_q;

	// next state
	logic [TS-1:0] now_n, last_cmd_n, dl_n;
	logic [7:0]    blink_sub_n;
	logic          blink_par_n;
	logic          play_n, req_ok, lost;
	logic [2:0]    act_n;
	logic [4:0]    step_n;
	logic [7:0]    left_n, right_n;
	logic [2:0]    led_n;
	logic [15:0]   cool_sel;
	hps_step_t     st;
	hps_line_evt_t evt;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign proc      = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_timeout_q <= RST_LINK_TIMEOUT;
			cool_bollard_q <= RST_COOL_BOLLARD;
			cool_red_q     <= RST_COOL_RED;
			cool_green_q   <= RST_COOL_GREEN;
			kick_q         <= RST_KICK_LEVEL;
			hold_q         <= RST_HOLD_LEVEL;
			high_q         <= RST_HIGH_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				CFG_COOL_BOLLARD: cool_bollard_q <= cfg_data;
				CFG_COOL_RED:     cool_red_q     <= cfg_data;
				CFG_COOL_GREEN:   cool_green_q   <= cfg_data;
				CFG_KICK_LEVEL:   kick_q         <= cfg_data[7:0];
				CFG_HOLD_LEVEL:   hold_q         <= cfg_data[7:0];
				CFG_HIGH_LEVEL:   high_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
	end

	hps_line_parser #(
		.LINE_MAX(LINE_MAX)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc && item_s1.cmd),
		.rx_byte(item_s1.rx_byte),
		.evt    (evt)
	);

	always_comb begin
		unique case (evt.pat)
			PAT_RED:   cool_sel = cool_red_q;
			PAT_GREEN: cool_sel = cool_green_q;
			default:   cool_sel = cool_bollard_q;
		endcase
	end

	always_comb begin
		// clock and blink phase
		now_n       = now_q;
		blink_sub_n = blink_sub_q;
		blink_par_n = blink_par_q;
		if (!item_s1.cmd) begin
			now_n = now_q + TS'(1);
			if (now_n == '0) begin
				blink_sub_n = 8'd0;
				blink_par_n = 1'b0;
			end else if (blink_sub_q == 8'(BLINK_MS - 1)) begin
				blink_sub_n = 8'd0;
				blink_par_n = !blink_par_q;
			end else begin
				blink_sub_n = blink_sub_q + 8'd1;
			end
		end

		// end of line: refresh and pattern request
		last_cmd_n = evt.refresh ? now_q : last_cmd_q;
		led_n      = evt.led_we ? evt.led : led_q;
		req_ok = evt.req && !(play_q && (prio_of(evt.pat) <= prio_of(act_q))) &&
		         ((now_q - last_start_q[evt.pat]) >= TS'(cool_sel)) ? 1'b1 : 1'b0;
		play_n  = play_q;
		act_n   = act_q;
		step_n  = step_q;
		dl_n    = dl_q;
		left_n  = left_q;
		right_n = right_q;
		if (req_ok) begin
			play_n = 1'b1;
			act_n  = evt.pat;
			step_n = 5'd0;
			dl_n   = now_q;
		end

		// link watchdog
		lost = (now_n - last_cmd_n) > TS'(link_timeout_q);
		if (lost) begin
			play_n  = 1'b0;
			left_n  = 8'd0;
			right_n = 8'd0;
			led_n   = blink_par_n ? LED_RED : LED_OFF;
		end

		// step player
		st = step_rom(act_n, step_n);
		if (play_n && !(now_n < dl_n)) begin
			if (st.ms == 10'd0) begin
				play_n  = 1'b0;
				left_n  = 8'd0;
				right_n = 8'd0;
			end else begin
				left_n  = level_of(st.l, kick_q, hold_q, high_q);
				right_n = level_of(st.r, kick_q, hold_q, high_q);
				dl_n    = now_n + TS'(st.ms);
				step_n  = step_n + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			last_cmd_q  <= '0;
			dl_q        <= '0;
			blink_sub_q <= 8'd0;
			blink_par_q <= 1'b0;
			play_q      <= 1'b0;
			act_q       <= PAT_LEFT;
			step_q      <= 5'd0;
			left_q      <= 8'd0;
			right_q     <= 8'd0;
			led_q       <= LED_OFF;
			for (int i = 0; i < NPAT; i++) last_start_q[i] <= '0;
		end else if (proc) begin
			now_q       <= now_n;
			last_cmd_q  <= last_cmd_n;
			dl_q        <= dl_n;
			blink_sub_q <= blink_sub_n;
			blink_par_q <= blink_par_n;
			play_q      <= play_n;
			act_q       <= act_n;
			step_q      <= step_n;
			left_q      <= left_n;
			right_q     <= right_n;
			led_q       <= led_n;
			if (req_ok) last_start_q[evt.pat] <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q.motor_left   <= left_n;
			out_q.motor_right  <= right_n;
			out_q.led_red      <= led_n[0];
			out_q.led_green    <= led_n[1];
			out_q.led_blue     <= led_n[2];
			out_q.pattern_busy <= play_n;
			out_q.pattern_id   <= play_n ? act_n : PAT_LEFT;
			out_q.link_lost    <= lost;
		end
	end

`ifndef SYNTHESIS
	// watchdog trip always silences the motors and stops playback
	a_lost_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.link_lost |->
			out_data.motor_left == 8'd0 && out_data.motor_right == 8'd0 &&
			!out_data.pattern_busy)
		else $error("motors driven after link loss");

	// motors only run while a pattern plays
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pattern_busy |->
			out_data.motor_left == 8'd0 && out_data.motor_right == 8'd0)
		else $error("motor level while idle");

	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		blink_sub_q < 8'(BLINK_MS))
		else $error("blink phase counter out of range");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= 5'(LAST_STEP))
		else $error("step index past pattern table");
`endif

endmodule

// ===== sv/hps_line_parser.sv =====
// hps_line_parser: collects received bytes into a command line and decodes
// it on CR or LF. Depends on hps_pkg.
`timescale 1ns / 1ps

module hps_line_parser #(
	parameter int LINE_MAX = hps_pkg::LINE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            rx_byte,
	output hps_pkg::hps_line_evt_t evt
);
	import hps_pkg::*;

	localparam int LW = $clog2(LINE_MAX + 1);

	logic [LW-1:0] len_q;
	logic [1:0]    cnt_q;
	logic [7:0]    first_q;
	logic          is_eol, is_ws;

	assign is_eol = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign is_ws  = (rx_byte == CH_SP) || (rx_byte == CH_TAB) ||
	                (rx_byte == CH_VT) || (rx_byte == CH_FF);

	always_comb begin
		evt = '0;
		if (en && is_eol) begin
			evt.refresh = (cnt_q != 2'd0);
			if (cnt_q == 2'd1) begin
				unique case (first_q)
					CH_4: begin
						evt.led_we = 1'b1; evt.led = LED_BLUE; evt.req = 1'b1; evt.pat = PAT_LEFT;
					end
					CH_5: begin
						evt.led_we = 1'b1; evt.led = LED_BLUE; evt.req = 1'b1; evt.pat = PAT_RIGHT;
					end
					CH_1: begin
						evt.led_we = 1'b1; evt.led = LED_BLUE; evt.req = 1'b1; evt.pat = PAT_FRONT;
					end
					CH_2: begin
						evt.led_we = 1'b1; evt.led = LED_RED; evt.req = 1'b1; evt.pat = PAT_RED;
					end
					CH_3: begin
						evt.led_we = 1'b1; evt.led = LED_GREEN; evt.req = 1'b1; evt.pat = PAT_GREEN;
					end
					CH_0: begin
						evt.led_we = 1'b1; evt.led = LED_OFF;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			cnt_q   <= 2'd0;
			first_q <= 8'd0;
		end else if (en) begin
			if (is_eol) begin
				len_q   <= '0;
				cnt_q   <= 2'd0;
				first_q <= 8'd0;
			end else if (len_q < LW'(LINE_MAX)) begin
				len_q <= len_q + LW'(1);
				if (!is_ws) begin
					if (cnt_q == 2'd0) first_q <= rx_byte;
					if (cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

endmodule
